>>> design/aes128_pkg.sv
// Shared constants, S-box table and round functions for the AES-128 pipeline.
package aes128_pkg;

  localparam int unsigned Rounds  = 10;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] KeyHighIdx = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] KeyLowIdx  = CfgIdxW'(1);

  localparam logic [7:0] GfReduce = 8'h1b;

  // Round constants, first is 0x01 and each one is the GF(2^8) double of the last.
  localparam logic [7:0] Rcon [Rounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  typedef logic [127:0] block_t;

  // Byte n of a block, byte 0 in the top bits.
  function automatic logic [7:0] get_byte(block_t s, int unsigned n);
    return s[127 - 8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfReduce : 8'h00);
  endfunction

  // SubBytes followed by ShiftRows; byte 4c+r is row r of column c.
  function automatic block_t sub_shift(block_t s);
    block_t t;
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = Sbox[get_byte(s, 4*((c + r) & 3) + r)];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int unsigned c = 0; c < 4; c++) begin
      a0  = get_byte(s, 4*c);
      a1  = get_byte(s, 4*c + 1);
      a2  = get_byte(s, 4*c + 2);
      a3  = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)     -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // One step of the key schedule, done on 32-bit words.
  function automatic block_t next_key(block_t rk, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w0 = rk[127:96] ^ {Sbox[get_byte(rk, 13)] ^ rc, Sbox[get_byte(rk, 14)],
                       Sbox[get_byte(rk, 15)], Sbox[get_byte(rk, 12)]};
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0]  ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

>>> design/aes128_stage.sv
// One pipelined AES round: AddRoundKey, SubBytes, ShiftRows, MixColumns and key step.
module aes128_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rc_i,
  input  logic                last_i,
  input  logic                valid_i,
  output logic                stall_o,
  input  aes128_pkg::block_t  blk_i,
  input  aes128_pkg::block_t  rk_i,
  output logic                valid_o,
  input  logic                stall_i,
  output aes128_pkg::block_t  blk_o,
  output aes128_pkg::block_t  rk_o
);
  import aes128_pkg::*;

  logic   valid_q;
  logic   load;
  block_t blk_d, blk_q;
  block_t rk_d, rk_q;
  block_t ss;

  // Slot is free when empty or when its beat leaves this cycle.
  assign stall_o = valid_q & stall_i;
  assign load    = valid_i & ~stall_o;

  always_comb begin
    ss    = sub_shift(blk_i ^ rk_i);
    rk_d  = next_key(rk_i, rc_i);
    // Last round skips MixColumns and folds in the final round key.
    blk_d = last_i ? (ss ^ rk_d) : mix_columns(ss);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= blk_d;
      rk_q  <= rk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;
  assign rk_o    = rk_q;

endmodule

>>> design/aes128_block_encrypt.sv
// Top level: AES-128 ECB encryption, ten-stage round pipeline with key registers.
//
// Usage:
//   The key is loaded over the cfg channel (index 0 = key bytes 0..7, index 1 =
//   key bytes 8..15); cfg_ready_o is always high and other indexes are dropped.
//   Load the key only while no block is in flight.
//   Plaintext beats enter on in_valid_i/in_stall_o, ciphertext beats leave on
//   out_valid_o/out_stall_i. Byte 0 is the most significant byte of the high half.
// Pipeline and throughput:
//   One round per register stage, ten stages. A block accepted at the input
//   moves through the stage registers in order, then is presented on the output.
//   With no stall one block is taken and one delivered every cycle.
//   The round key travels down the pipe next to each block, one schedule step
//   per stage, so stage depth is one S-box, MixColumns and a few XORs.
// Stall:
//   Holding out_stall_i freezes the output beat; bubbles in the pipe still fill
//   up, and in_stall_o rises only once the beat at each stage has nowhere to go.
//   Nothing is dropped or repeated.
// Reset:
//   Clears all stage valid bits and both key registers to zero.
module aes128_block_encrypt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aes128_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   plain_high_i,
  input  logic [63:0]                   plain_low_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   cipher_high_o,
  output logic [63:0]                   cipher_low_o
);
  import aes128_pkg::*;

  logic [63:0] key_high_q, key_low_q;

  logic   valid_s [Rounds];
  logic   stall_s [Rounds];
  block_t blk_s   [Rounds];
  block_t rk_s    [Rounds-1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        KeyHighIdx: key_high_q <= cfg_data_i;
        KeyLowIdx:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < Rounds; k++) begin : g_round
    if (k == 0) begin : g_first
      aes128_stage u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .rc_i    (Rcon[k]),
        .last_i  (1'b0),
        .valid_i (in_valid_i),
        .stall_o (stall_s[k]),
        .blk_i   ({plain_high_i, plain_low_i}),
        .rk_i    ({key_high_q, key_low_q}),
        .valid_o (valid_s[k]),
        .stall_i (stall_s[k+1]),
        .blk_o   (blk_s[k]),
        .rk_o    (rk_s[k])
      );
    end else if (k == Rounds - 1) begin : g_last
      aes128_stage u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .rc_i    (Rcon[k]),
        .last_i  (1'b1),
        .valid_i (valid_s[k-1]),
        .stall_o (stall_s[k]),
        .blk_i   (blk_s[k-1]),
        .rk_i    (rk_s[k-1]),
        .valid_o (valid_s[k]),
        .stall_i (out_stall_i),
        .blk_o   (blk_s[k]),
        .rk_o    ()
      );
    end else begin : g_mid
      aes128_stage u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .rc_i    (Rcon[k]),
        .last_i  (1'b0),
        .valid_i (valid_s[k-1]),
        .stall_o (stall_s[k]),
        .blk_i   (blk_s[k-1]),
        .rk_i    (rk_s[k-1]),
        .valid_o (valid_s[k]),
        .stall_i (stall_s[k+1]),
        .blk_o   (blk_s[k]),
        .rk_o    (rk_s[k])
      );
    end
  end

  assign in_stall_o    = stall_s[0];
  assign out_valid_o   = valid_s[Rounds-1];
  assign cipher_high_o = blk_s[Rounds-1][127:64];
  assign cipher_low_o  = blk_s[Rounds-1][63:0];

endmodule

>>> design/aes128_check.sv
// Port-level checker for the AES-128 pipeline and its bind to the top level.
module aes128_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] cipher_high_o,
  input logic [63:0] cipher_low_o
);
  import aes128_pkg::*;

  // Count of consecutive edges with the output side not stalling.
  logic [3:0] run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (out_stall_i) begin
      run_q <= '0;
    end else if (run_q != 4'd15) begin
      run_q <= run_q + 4'd1;
    end
  end

  // Input is only held off when the output side is holding off.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled while output not stalled");

  // A beat accepted into a free-running pipe comes out once it has passed every stage register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_valid_i && !in_stall_o && rst_ni, 10) && $past(rst_ni, 9) && run_q >= 4'd9)
    |-> out_valid_o)
    else $error("beat did not reach output in ten cycles");

  // Stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(cipher_high_o)
      && $stable(cipher_low_o)))
    else $error("stalled output beat changed");

  // Output valid drops only after the beat was taken.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output beat lost");

endmodule

bind aes128_block_encrypt aes128_check u_aes128_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .cipher_high_o (cipher_high_o),
  .cipher_low_o  (cipher_low_o)
);
